FILE: hw/rtl/sra_pkg.sv
package sra_pkg;

  localparam int SIZE_W = 5;
  localparam int COORD_W = 4;
  localparam int COL_W = 12;
  localparam int VAL_W = 36;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_ASSEMBLE = 1'b1;

  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_NEG_LIMIT = {1'b1, {(VAL_W-1){1'b0}}};

  typedef logic [SIZE_W-1:0] size_t;

endpackage

FILE: hw/rtl/stencil_row_assembler_top.sv
// Channel   Direction  Handshake         Payload
// command   in         start & !busy     mode, cell_x/y/z, cond_x/y/z
// result    out        strobe (1 cycle)  column, value, last, status
// config    in         cfg_valid&ready   cfg_index, cfg_data
// A write word is stored in S_WR; an out-of-grid word gets its error word from S_ERR.
// An assemble word keeps busy high while the one-bit-per-cycle divider computes
// each harmonic mean in turn.
// Reset clears the control and sets every size to 16; the memories are not cleared.
// The receiver cannot stall; results leave on consecutive cycles at the end of the row.
module stencil_row_assembler_top #(
  parameter int MAX_EXTENT = 16,
  parameter int COEFF_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          mode,
  input  logic [3:0]                    cell_x,
  input  logic [3:0]                    cell_y,
  input  logic [3:0]                    cell_z,
  input  logic [31:0]                   cond_x,
  input  logic [31:0]                   cond_y,
  input  logic [31:0]                   cond_z,
  output logic                          strobe,
  output logic [11:0]                   column,
  output logic signed [35:0]            value,
  output logic                          last,
  output logic                          status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sra_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sra_pkg::SIZE_W-1:0]    cfg_data
);
  import sra_pkg::*;

  localparam int EXT_W = (MAX_EXTENT > 1) ? $clog2(MAX_EXTENT) : 1;
  localparam int AW = 3 * EXT_W;
  localparam int DEPTH = MAX_EXTENT * MAX_EXTENT * MAX_EXTENT;
  localparam int CW = COEFF_BITS;
  localparam int PW = 2 * CW + 1;
  localparam int SW = CW + 1;
  localparam int QW = PW;
  localparam int BW = $clog2(PW + 1);
  localparam int DW = ((CW > VAL_W) ? CW : VAL_W) + 4;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RDME = 4'd1;
  localparam logic [3:0] S_ME = 4'd2;
  localparam logic [3:0] S_NB = 4'd3;
  localparam logic [3:0] S_NBW = 4'd4;
  localparam logic [3:0] S_MUL = 4'd5;
  localparam logic [3:0] S_DIV = 4'd6;
  localparam logic [3:0] S_ACC = 4'd7;
  localparam logic [3:0] S_EMIT = 4'd8;
  localparam logic [3:0] S_ERR = 4'd9;
  localparam logic [3:0] S_WR = 4'd10;

  logic [3:0] state;
  size_t size_x, size_y, size_z;
  logic [EXT_W:0] nx, ny, nz;
  logic [3:0] x, y, z;
  logic [CW-1:0] wx, wy, wz;
  logic [2:0] nb;
  logic [5:0] nb_ok;
  logic [CW-1:0] me_x, me_y, me_z;
  logic [CW-1:0] rd_x, rd_y, rd_z;
  logic [AW-1:0] raddr;
  logic [SW-1:0] dsum;
  logic [PW-1:0] dividend;
  logic [SW:0] rem;
  logic [QW-1:0] quo;
  logic [BW-1:0] bitc;
  logic [CW:0] means [6];
  logic [DW-1:0] diag;
  logic [COL_W-1:0] row, nynz;
  logic [2:0] eidx;
  logic [2:0] lastk;

  function automatic logic [EXT_W:0] clampsz(input size_t v);
    if (v == '0) return (EXT_W+1)'(1);
    if (32'(v) > MAX_EXTENT) return (EXT_W+1)'(MAX_EXTENT);
    return (EXT_W+1)'(v);
  endfunction

  assign nx = clampsz(size_x);
  assign ny = clampsz(size_y);
  assign nz = clampsz(size_z);
  assign cfg_ready = 1'b1;
  assign busy = (state != S_IDLE);

  function automatic logic [AW-1:0] addr(input logic [3:0] a, input logic [3:0] b,
                                         input logic [3:0] c);
    return {EXT_W'(a), EXT_W'(b), EXT_W'(c)};
  endfunction

  logic in_grid;
  assign in_grid = ({1'b0, cell_x} < 5'(nx)) && ({1'b0, cell_y} < 5'(ny))
                && ({1'b0, cell_z} < 5'(nz));

  always_comb begin
    unique case (nb)
      3'd0: raddr = addr(x - 4'd1, y, z);
      3'd1: raddr = addr(x, y - 4'd1, z);
      3'd2: raddr = addr(x, y, z - 4'd1);
      3'd3: raddr = addr(x, y, z + 4'd1);
      3'd4: raddr = addr(x, y + 4'd1, z);
      default: raddr = addr(x + 4'd1, y, z);
    endcase
    if (state == S_IDLE || state == S_RDME) begin
      raddr = addr(x, y, z);
    end
  end

  logic wen;
  assign wen = (state == S_WR);

  sra_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_ram_x (.clk(clk), .we(wen), .waddr(addr(x, y, z)),
    .wdata(wx), .raddr(raddr), .rdata(rd_x));
  sra_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_ram_y (.clk(clk), .we(wen), .waddr(addr(x, y, z)),
    .wdata(wy), .raddr(raddr), .rdata(rd_y));
  sra_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_ram_z (.clk(clk), .we(wen), .waddr(addr(x, y, z)),
    .wdata(wz), .raddr(raddr), .rdata(rd_z));

  always_comb begin
    nb_ok[0] = (x != 4'd0);
    nb_ok[1] = (y != 4'd0);
    nb_ok[2] = (z != 4'd0);
    nb_ok[3] = (5'(z) + 5'd1 < 5'(nz));
    nb_ok[4] = (5'(y) + 5'd1 < 5'(ny));
    nb_ok[5] = (5'(x) + 5'd1 < 5'(nx));
  end

  logic [CW-1:0] mea, neb;
  always_comb begin
    unique case (nb) inside
      3'd0, 3'd5: mea = me_x;
      3'd1, 3'd4: mea = me_y;
      default: mea = me_z;
    endcase
    unique case (nb) inside
      3'd0, 3'd5: neb = rd_x;
      3'd1, 3'd4: neb = rd_y;
      default: neb = rd_z;
    endcase
  end

  logic [SW:0] rem_sh;
  assign rem_sh = {rem[SW-1:0], dividend[PW-1]};

  // Entry k of the row: 0 is the diagonal, then the present neighbors in order.
  logic [2:0] sel;
  logic [2:0] cnt_before;
  always_comb begin
    sel = 3'd0;
    cnt_before = 3'd0;
    for (int k = 0; k < 6; k++) begin
      if (nb_ok[k]) begin
        cnt_before = cnt_before + 3'd1;
        if (cnt_before == eidx) sel = 3'(k);
      end
    end
  end

  logic [CW:0] mv;
  assign mv = means[sel];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      size_x <= 5'd16;
      size_y <= 5'd16;
      size_z <= 5'd16;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_SIZE_X: size_x <= cfg_data;
          REG_SIZE_Y: size_y <= cfg_data;
          REG_SIZE_Z: size_z <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            x <= cell_x;
            y <= cell_y;
            z <= cell_z;
            wx <= CW'(cond_x);
            wy <= CW'(cond_y);
            wz <= CW'(cond_z);
            if (!in_grid) state <= S_ERR;
            else if (mode == MODE_WRITE) state <= S_WR;
            else state <= S_RDME;
            row <= COL_W'(32'(cell_x) * 32'(ny) * 32'(nz) + 32'(cell_y) * 32'(nz)
                   + 32'(cell_z));
            nynz <= COL_W'(32'(ny) * 32'(nz));
          end
        end
        S_WR: state <= S_IDLE;
        S_ERR: begin
          strobe <= 1'b1;
          column <= '0;
          value <= '0;
          last <= 1'b1;
          status <= 1'b1;
          state <= S_IDLE;
        end
        S_RDME: state <= S_ME;
        S_ME: begin
          me_x <= rd_x;
          me_y <= rd_y;
          me_z <= rd_z;
          nb <= 3'd0;
          diag <= ((z == 4'd0) || (5'(z) == 5'(nz) - 5'd1))
                  ? DW'({rd_z, 1'b0}) : '0;
          for (int k = 0; k < 6; k++) means[k] <= '0;
          state <= S_NB;
        end
        S_NB: begin
          if (nb == 3'd6) begin
            eidx <= 3'd0;
            lastk <= 3'($countones(nb_ok));
            state <= S_EMIT;
          end else if (!nb_ok[nb]) begin
            nb <= nb + 3'd1;
          end else begin
            state <= S_NBW;
          end
        end
        S_NBW: state <= S_MUL;
        S_MUL: begin
          dsum <= SW'(mea) + SW'(neb);
          dividend <= {PW'(mea) * PW'(neb)} << 1;
          rem <= '0;
          quo <= '0;
          bitc <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (dsum == '0) begin
            quo <= '0;
            state <= S_ACC;
          end else begin
            dividend <= dividend << 1;
            if (rem_sh >= {1'b0, dsum}) begin
              rem <= rem_sh - {1'b0, dsum};
              quo <= {quo[QW-2:0], 1'b1};
            end else begin
              rem <= rem_sh;
              quo <= {quo[QW-2:0], 1'b0};
            end
            bitc <= bitc + BW'(1);
            if (32'(bitc) == PW - 1) state <= S_ACC;
          end
        end
        S_ACC: begin
          means[nb] <= (CW+1)'(quo);
          diag <= diag + DW'(quo[CW:0]);
          nb <= nb + 3'd1;
          state <= S_NB;
        end
        S_EMIT: begin
          strobe <= 1'b1;
          status <= 1'b0;
          last <= (eidx == lastk);
          if (eidx == 3'd0) begin
            column <= row;
            value <= (diag > DW'(VAL_MAX)) ? VAL_MAX : VAL_W'(diag);
          end else begin
            unique case (sel)
              3'd0: column <= row - nynz;
              3'd1: column <= row - COL_W'(nz);
              3'd2: column <= row - COL_W'(1);
              3'd3: column <= row + COL_W'(1);
              3'd4: column <= row + COL_W'(nz);
              default: column <= row + nynz;
            endcase
            value <= (DW'(mv) > DW'(VAL_NEG_LIMIT)) ? VAL_NEG_LIMIT
                     : VAL_W'(-DW'(mv));
          end
          eidx <= eidx + 3'd1;
          if (eidx == lastk) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    strobe && status |-> last && column == '0) else $error("error word not last");
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) && $past(state == S_IDLE) && !$past(rst) |-> !strobe)
    else $error("result while idle");
  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> 32'(bitc) < PW) else $error("divider overrun");

endmodule

FILE: hw/rtl/sra_ram.sv
module sra_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
